FILE: rtl/keypad_press_release_timer_core_assert.svh
// Assertion macros for the keypad timer RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef KEYPAD_PRESS_RELEASE_TIMER_CORE_ASSERT_SVH
`define KEYPAD_PRESS_RELEASE_TIMER_CORE_ASSERT_SVH

// same-cycle implication
`define KPRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KPRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kprt_pkg.sv
// Shared types, constants and key mapping helpers for the keypad timer.
// No dependencies.
`default_nettype none

package kprt_pkg;

  localparam int DEF_PANELS = 4;
  localparam int KEYS_PER_PANEL = 8;

  localparam logic [7:0] REPORT_KIND_KEYS = 8'd0;
  localparam logic [7:0] NON_KEY_TAG      = 8'd214;
  localparam logic [2:0] REMAP_ABOVE      = 3'd5;
  localparam logic [3:0] REMAP_SHIFT      = 4'd2;

  typedef enum logic {
    EV_PRESS   = 1'b0,
    EV_RELEASE = 1'b1
  } ev_kind_t;

  // one event handed from the scanner to the stamp stage
  typedef struct packed {
    ev_kind_t    kind;
    logic [5:0]  key_id;
    logic [31:0] stamp;
    logic        last;
  } issue_t;

  // bit index (2*col + row) -> key index (col + 4*row)
  function automatic logic [2:0] bit_to_key(input logic [2:0] b);
    return {b[0], b[2:1]};
  endfunction

  function automatic logic [3:0] key_to_id(input logic [2:0] k);
    return (k > REMAP_ABOVE) ? ({1'b0, k} + REMAP_SHIFT) : {1'b0, k};
  endfunction

  // panel * 10
  function automatic logic [5:0] panel_base(input logic [1:0] p);
    return {1'b0, p, 3'b000} + {3'b000, p, 1'b0};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kprt_scan.sv
// Report front end: per-panel key bits, change mask and event serializer.
// Depends on kprt_pkg.
`default_nettype none

module kprt_scan #(
  parameter int PANELS = kprt_pkg::DEF_PANELS,
  parameter int SLOT_W = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_panel,
  input  logic [7:0]          in_report_kind,
  input  logic [7:0]          in_report_tag,
  input  logic [1:0]          in_key_col0,
  input  logic [1:0]          in_key_col1,
  input  logic [1:0]          in_key_col2,
  input  logic [1:0]          in_key_col3,
  input  logic [31:0]         in_stamp,
  input  logic                adv,
  output logic                iss_fire,
  output kprt_pkg::issue_t    iss,
  output logic [SLOT_W-1:0]   iss_slot
);
  import kprt_pkg::*;

  localparam int PIDX_W = (PANELS > 1) ? $clog2(PANELS) : 1;

  logic [7:0]        prior_r [PANELS];
  logic              busy_r;
  logic [7:0]        mask_r;
  logic [7:0]        now_r;
  logic [1:0]        panel_r;
  logic [31:0]       stamp_r;

  logic              panel_ok;
  logic              handled;
  logic              accept;
  logic [7:0]        now;
  logic [7:0]        was;
  logic [7:0]        diff;
  logic [3:0]        pwide;
  logic [PIDX_W-1:0] pidx;
  logic [2:0]        pick;
  logic [7:0]        mask_left;
  logic              done;
  logic [2:0]        key;
  logic [7:0]        slot_wide;

  assign panel_ok  = {3'b000, in_panel} < 5'(PANELS);
  assign handled   = (in_report_kind == REPORT_KIND_KEYS) && (in_report_tag != NON_KEY_TAG)
                     && panel_ok;
  assign now       = {in_key_col3, in_key_col2, in_key_col1, in_key_col0};
  assign pwide     = {2'b00, in_panel};
  assign pidx      = pwide[PIDX_W-1:0];
  assign was       = prior_r[pidx];
  assign diff      = was ^ now;

  // lowest changed bit first: column-major scan order
  always_comb begin
    pick = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_r[i]) pick = 3'(i);
    end
  end

  assign mask_left = mask_r & ~(8'b1 << pick);
  assign iss_fire  = busy_r & adv;
  assign done      = iss_fire & (mask_left == 8'd0);
  assign in_stall  = busy_r & ~done;
  assign accept    = in_valid & ~in_stall;

  assign key        = bit_to_key(pick);
  assign iss.kind   = now_r[pick] ? EV_PRESS : EV_RELEASE;
  assign iss.key_id = panel_base(panel_r) + {2'b00, key_to_id(key)};
  assign iss.stamp  = stamp_r;
  assign iss.last   = (mask_left == 8'd0);
  assign slot_wide  = {3'b000, panel_r, key};
  assign iss_slot   = slot_wide[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PANELS; p++) prior_r[p] <= '0;
    end else if (accept && handled) begin
      prior_r[pidx] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept && handled && (diff != 8'd0)) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && handled && (diff != 8'd0)) begin
      mask_r  <= diff;
      now_r   <= now;
      panel_r <= in_panel;
      stamp_r <= in_stamp;
    end else if (iss_fire) begin
      mask_r  <= mask_left;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kprt_stamp_ram.sv
// Press stamp store: synchronous RAM, one write and one registered read
// port, per-entry valid bits so unwritten entries read as zero. Uses no package.
`default_nettype none

module kprt_stamp_ram #(
  parameter int DEPTH  = 32,
  parameter int SLOT_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [31:0]       rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [31:0]       wr_data
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [31:0]      rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : 32'd0;

endmodule

`default_nettype wire

FILE: rtl/kprt_event.sv
// Event stage: takes the stamp read, forwards a same-slot write, computes
// hold time, writes the slot back and drives the output register. Uses kprt_pkg.
`default_nettype none

`include "keypad_press_release_timer_core_assert.svh"

module kprt_event #(
  parameter int SLOT_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              iss_fire,
  input  kprt_pkg::issue_t  iss,
  input  logic [SLOT_W-1:0] iss_slot,
  input  logic [31:0]       rd_data,
  output logic              wr_en,
  output logic [SLOT_W-1:0] wr_addr,
  output logic [31:0]       wr_data,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_event_kind,
  output logic [5:0]        out_key_id,
  output logic [31:0]       out_event_time,
  output logic [31:0]       out_held_for,
  output logic              out_last_event
);
  import kprt_pkg::*;

  logic              b_valid_r;
  issue_t            b_iss_r;
  logic [SLOT_W-1:0] b_slot_r;
  logic              fwd_r;
  logic [31:0]       fwd_data_r;

  logic              out_valid_r;
  ev_kind_t          out_kind_r;
  logic [5:0]        out_key_id_r;
  logic [31:0]       out_time_r;
  logic [31:0]       out_held_r;
  logic              out_last_r;

  logic [31:0]       stored;
  logic [31:0]       held;

  assign adv     = ~out_valid_r | ~out_stall;
  assign wr_en   = b_valid_r & adv;
  assign wr_addr = b_slot_r;
  assign wr_data = (b_iss_r.kind == EV_PRESS) ? b_iss_r.stamp : 32'd0;

  // RAM read is registered and misses a same-cycle write: a write to the same slot in the issue cycle wins
  assign stored = fwd_r ? fwd_data_r : rd_data;
  assign held   = (b_iss_r.kind == EV_RELEASE) ? (b_iss_r.stamp - stored) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else if (adv) begin
      b_valid_r <= iss_fire;
      fwd_r     <= wr_en && iss_fire && (b_slot_r == iss_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_iss_r    <= iss;
      b_slot_r   <= iss_slot;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid_r) begin
      out_kind_r   <= b_iss_r.kind;
      out_key_id_r <= b_iss_r.key_id;
      out_time_r   <= b_iss_r.stamp;
      out_held_r   <= held;
      out_last_r   <= b_iss_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_key_id     = out_key_id_r;
  assign out_event_time = out_time_r;
  assign out_held_for   = out_held_r;
  assign out_last_event = out_last_r;

  `KPRT_ASSERT_NOW(a_press_no_hold, out_valid_r && (out_kind_r == EV_PRESS),
                   out_held_r == 32'd0, "press word carries hold time")
  `KPRT_ASSERT_NEXT(a_stage_holds, b_valid_r && !adv, b_valid_r && $stable(b_slot_r),
                    "event stage dropped a word under stall")
  `KPRT_ASSERT_NOW(a_fwd_needs_word, fwd_r, b_valid_r,
                   "forward flag without a word in the event stage")

endmodule

`default_nettype wire

FILE: rtl/keypad_press_release_timer_core.sv
// Keypad press/release timer, top level.
// Input channel (in_*): one status report per word; only reports with kind 0,
// tag other than 214 and a panel below PANELS are processed, others are
// dropped without effect. Each processed report is compared with the panel's
// stored key bits and yields one output word (out_*) per changed key, in
// column-major order, out_last_event set on the final one; an unchanged
// report yields nothing.
// Throughput: one event word per cycle while the output is not stalled.
// in_stall is high while a taken report still has events to issue, apart
// from the cycle in which its last event issues; the next report is taken
// in that cycle. An accepted report passes the scan register, the stamp
// RAM read stage and the output register before its first word is valid.
// Press stamps live in a PANELS*8 x 32 RAM read at issue, before the event
// stage writes the slot back; a write to the same slot in the issue cycle is
// forwarded. Reset clears stored key bits and marks every stamp entry as
// zero at once; no clearing pass. A stalled output holds its word and
// freezes the event stage and scanner; an idle scanner still takes a report.
`default_nettype none

module keypad_press_release_timer_core #(
  parameter int PANELS = kprt_pkg::DEF_PANELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_panel,
  input  logic [7:0]  in_report_kind,
  input  logic [7:0]  in_report_tag,
  input  logic [1:0]  in_key_col0,
  input  logic [1:0]  in_key_col1,
  input  logic [1:0]  in_key_col2,
  input  logic [1:0]  in_key_col3,
  input  logic [31:0] in_stamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_kind,
  output logic [5:0]  out_key_id,
  output logic [31:0] out_event_time,
  output logic [31:0] out_held_for,
  output logic        out_last_event
);
  import kprt_pkg::*;

  localparam int DEPTH  = PANELS * KEYS_PER_PANEL;
  localparam int SLOT_W = $clog2(DEPTH);

  logic              adv;
  logic              iss_fire;
  issue_t            iss;
  logic [SLOT_W-1:0] iss_slot;
  logic [31:0]       rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  kprt_scan #(
    .PANELS (PANELS),
    .SLOT_W (SLOT_W)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_panel       (in_panel),
    .in_report_kind (in_report_kind),
    .in_report_tag  (in_report_tag),
    .in_key_col0    (in_key_col0),
    .in_key_col1    (in_key_col1),
    .in_key_col2    (in_key_col2),
    .in_key_col3    (in_key_col3),
    .in_stamp       (in_stamp),
    .adv            (adv),
    .iss_fire       (iss_fire),
    .iss            (iss),
    .iss_slot       (iss_slot)
  );

  kprt_stamp_ram #(
    .DEPTH  (DEPTH),
    .SLOT_W (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (iss_fire),
    .rd_addr (iss_slot),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  kprt_event #(
    .SLOT_W (SLOT_W)
  ) u_event (
    .clk            (clk),
    .rst_n          (rst_n),
    .iss_fire       (iss_fire),
    .iss            (iss),
    .iss_slot       (iss_slot),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_key_id     (out_key_id),
    .out_event_time (out_event_time),
    .out_held_for   (out_held_for),
    .out_last_event (out_last_event)
  );

endmodule

`default_nettype wire
